### rtl/scan_code_keyboard_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scan code keyboard decoder
// Concurrent checks clocked by clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SCAN_CODE_KEYBOARD_DECODER_ASSERT_SVH
`define SCAN_CODE_KEYBOARD_DECODER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg
// Shared types, codes and lookup tables of the scan code keyboard decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

  // Default sizes
  localparam int RING_DEPTH_DEF = 64;
  localparam int KEY_COUNT_DEF  = 128;

  // Host command codes
  typedef enum logic [2:0] {
    CMD_RAW   = 3'd0,
    CMD_KEY   = 3'd1,
    CMD_POP   = 3'd2,
    CMD_PUSH  = 3'd3,
    CMD_FLUSH = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_QUERY = 3'd6,
    CMD_NOP   = 3'd7
  } cmd_t;

  // Keyboard port bytes and key numbers
  localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
  localparam logic [7:0] BYTE_EXT    = 8'hE0;
  localparam logic [6:0] FAKE_SHIFT  = 7'h2A;
  localparam logic [2:0] PAUSE_SKIP  = 3'd5;
  localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT  = 8'h36;
  localparam logic [7:0] KEY_CAPS    = 8'h3A;
  localparam logic [7:0] KEY_PAUSE   = 8'h59;
  localparam logic [7:0] ASCII_LIMIT = 8'h3A;

  // One item as seen by the processing stage
  typedef struct packed {
    logic       fire;
    cmd_t       cmd;
    logic [7:0] raw_byte;
    logic [6:0] key_index;
    logic       pressed;
    logic [7:0] push_char;
  } step_t;

  // Character handed from the key logic to the ring
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  // Extended key lookup result
  typedef struct packed {
    logic       hit;
    logic [7:0] key;
  } ext_t;

  function automatic ext_t ext_key(input logic [6:0] code);
    ext_t r;
    r.hit = 1'b1;
    unique case (code)
      7'h48:   r.key = 8'h5A;
      7'h50:   r.key = 8'h6A;
      7'h4B:   r.key = 8'h6B;
      7'h4D:   r.key = 8'h6C;
      7'h52:   r.key = 8'h5E;
      7'h53:   r.key = 8'h5F;
      7'h47:   r.key = 8'h61;
      7'h4F:   r.key = 8'h62;
      7'h49:   r.key = 8'h63;
      7'h51:   r.key = 8'h64;
      7'h38:   r.key = 8'hB8;
      7'h1D:   r.key = 8'h9D;
      7'h35:   r.key = 8'hB5;
      7'h1C:   r.key = 8'h9C;
      7'h37:   r.key = 8'hB7;
      default: begin
        r.hit = 1'b0;
        r.key = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] k);
    return (k >= 8'h10 && k <= 8'h19) || (k >= 8'h1E && k <= 8'h26) ||
           (k >= 8'h2C && k <= 8'h32);
  endfunction

  // Unshifted character of a key below the ASCII limit
  function automatic logic [7:0] plain_char(input logic [5:0] k);
    logic [7:0] c;
    unique case (k)
      6'h01: c = 8'h1B;
      6'h02: c = 8'h31;
      6'h03: c = 8'h32;
      6'h04: c = 8'h33;
      6'h05: c = 8'h34;
      6'h06: c = 8'h35;
      6'h07: c = 8'h36;
      6'h08: c = 8'h37;
      6'h09: c = 8'h38;
      6'h0A: c = 8'h39;
      6'h0B: c = 8'h30;
      6'h0C: c = 8'h2D;
      6'h0D: c = 8'h3D;
      6'h0E: c = 8'h08;
      6'h0F: c = 8'h09;
      6'h10: c = 8'h71;
      6'h11: c = 8'h77;
      6'h12: c = 8'h65;
      6'h13: c = 8'h72;
      6'h14: c = 8'h74;
      6'h15: c = 8'h79;
      6'h16: c = 8'h75;
      6'h17: c = 8'h69;
      6'h18: c = 8'h6F;
      6'h19: c = 8'h70;
      6'h1A: c = 8'h5B;
      6'h1B: c = 8'h5D;
      6'h1C: c = 8'h0D;
      6'h1E: c = 8'h61;
      6'h1F: c = 8'h73;
      6'h20: c = 8'h64;
      6'h21: c = 8'h66;
      6'h22: c = 8'h67;
      6'h23: c = 8'h68;
      6'h24: c = 8'h6A;
      6'h25: c = 8'h6B;
      6'h26: c = 8'h6C;
      6'h27: c = 8'h3B;
      6'h28: c = 8'h27;
      6'h29: c = 8'h60;
      6'h2B: c = 8'h5C;
      6'h2C: c = 8'h7A;
      6'h2D: c = 8'h78;
      6'h2E: c = 8'h63;
      6'h2F: c = 8'h76;
      6'h30: c = 8'h62;
      6'h31: c = 8'h6E;
      6'h32: c = 8'h6D;
      6'h33: c = 8'h2C;
      6'h34: c = 8'h2E;
      6'h35: c = 8'h2F;
      6'h37: c = 8'h2A;
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted character: symbols by table, letters as upper case
  function automatic logic [7:0] shift_char(input logic [5:0] k);
    logic [7:0] c;
    unique case (k)
      6'h02: c = 8'h21;
      6'h03: c = 8'h40;
      6'h04: c = 8'h23;
      6'h05: c = 8'h24;
      6'h06: c = 8'h25;
      6'h07: c = 8'h5E;
      6'h08: c = 8'h26;
      6'h09: c = 8'h2A;
      6'h0A: c = 8'h28;
      6'h0B: c = 8'h29;
      6'h0C: c = 8'h5F;
      6'h0D: c = 8'h2B;
      6'h1A: c = 8'h7B;
      6'h1B: c = 8'h7D;
      6'h27: c = 8'h3A;
      6'h28: c = 8'h22;
      6'h29: c = 8'h7E;
      6'h2B: c = 8'h7C;
      6'h33: c = 8'h3C;
      6'h34: c = 8'h3E;
      6'h35: c = 8'h3F;
      default: c = is_letter({2'b00, k}) ? (plain_char(k) - 8'h20) : plain_char(k);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/scan_code_keyboard_decoder.sv
// ---------------------------------------------------------------------------
// scan_code_keyboard_decoder
// Set-1 scan code decoder with key-down map and character ring.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) carries one command per
//   transfer: keyboard byte, key event, pop, push, flush, clear keys, query.
//   The master channel (m_tvalid/m_tready/m_tdata) returns exactly one result
//   per command: popped character and its valid flag, query answer, last
//   pressed key and the ring fill after the command.
//   Each command is captured in the input register, passes once through the
//   decode and ring logic, and its result is captured in the result register.
//   Throughput: one command per cycle while the receiver takes the results.
//   When the receiver stalls, the result is held, one more command waits in
//   the input register, and s_tready drops until the result is taken.
//   Reset clears the key map, last key, prefix state and ring pointers at
//   once; no clearing pass is run and ring contents are undefined until
//   written. The ring holds RING_DEPTH-1 characters.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_code_keyboard_decoder import scd_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int KEY_COUNT  = KEY_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[2:0], raw_byte[10:3], key_index[17:11], pressed[18], push_char[26:19]
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // char_out[7:0], char_valid[8], key_is_down[9], last_key[16:10], queue_count[22:17]
  output logic [23:0]      m_tdata
);

  logic        in_full;
  logic [26:0] in_data;
  logic        fire;
  step_t       step;
  push_t       key_push;
  logic        key_is_down;
  logic [6:0]  last_key;
  logic [7:0]  char_out;
  logic        char_valid;
  logic [5:0]  queue_count;

  // Process the held command when the result register is free
  assign fire     = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || fire;

  always_comb begin
    step.fire      = fire;
    step.cmd       = cmd_t'(in_data[2:0]);
    step.raw_byte  = in_data[10:3];
    step.key_index = in_data[17:11];
    step.pressed   = in_data[18];
    step.push_char = in_data[26:19];
  end

  // Hold the accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[26:0];
    end
  end

  scd_keys #(
    .KEY_COUNT (KEY_COUNT)
  ) u_keys (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .key_is_down (key_is_down),
    .last_key    (last_key),
    .key_push    (key_push)
  );

  scd_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .key_push    (key_push),
    .char_out    (char_out),
    .char_valid  (char_valid),
    .queue_count (queue_count)
  );

  // Register the result and hold it until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, queue_count, last_key, key_is_down, char_valid, char_out};
    end
  end

endmodule

`default_nettype wire

### rtl/scd_keys.sv
// ---------------------------------------------------------------------------
// scd_keys
// Byte prefix handling, key-down map, last key and ASCII translation.
// ---------------------------------------------------------------------------
`default_nettype none

module scd_keys import scd_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire step_t      step,
  output logic            key_is_down,
  output logic [6:0]      last_key,
  output push_t           key_push
);

  localparam int         KIDX_W    = $clog2(KEY_COUNT);
  localparam logic [8:0] KEY_LIMIT = 9'(KEY_COUNT);

  logic [KEY_COUNT-1:0] key_map;
  logic [KEY_COUNT-1:0] key_map_next;
  logic [6:0]           last_pressed;
  logic [6:0]           last_pressed_next;
  logic                 ext_pending;
  logic                 ext_pending_next;
  logic [2:0]           skip_left;
  logic [2:0]           skip_left_next;

  logic                 ev_valid;
  logic [7:0]           ev_key;
  logic                 ev_down;
  logic                 ev_ok;
  logic [KIDX_W-1:0]    ev_idx;
  logic                 shift_on;
  logic [7:0]           ev_char;
  ext_t                 ext;

  // Turn a raw byte or a key event command into at most one key event
  always_comb begin
    skip_left_next   = skip_left;
    ext_pending_next = ext_pending;
    ev_valid         = 1'b0;
    ev_key           = 8'h00;
    ev_down          = 1'b0;
    ext              = ext_key(step.raw_byte[6:0]);
    if (step.fire) begin
      unique case (step.cmd)
        CMD_RAW: begin
          priority if (skip_left != 3'd0) begin
            skip_left_next = skip_left - 3'd1;
          end else if (step.raw_byte == BYTE_PAUSE) begin
            ev_valid       = 1'b1;
            ev_key         = KEY_PAUSE;
            ev_down        = 1'b1;
            skip_left_next = PAUSE_SKIP;
          end else if (step.raw_byte == BYTE_EXT) begin
            ext_pending_next = 1'b1;
          end else if (ext_pending) begin
            ext_pending_next = 1'b0;
            // drop the fake shift codes and unmapped extended codes
            if (step.raw_byte[6:0] != FAKE_SHIFT && ext.hit) begin
              ev_valid = 1'b1;
              ev_key   = ext.key;
              ev_down  = !step.raw_byte[7];
            end
          end else begin
            ev_valid = 1'b1;
            ev_key   = {1'b0, step.raw_byte[6:0]};
            ev_down  = !step.raw_byte[7];
          end
        end
        CMD_KEY: begin
          ev_valid = 1'b1;
          ev_key   = {1'b0, step.key_index};
          ev_down  = step.pressed;
        end
        default: begin
        end
      endcase
    end
  end

  // Translate the key with shift, caps applying to letters only
  always_comb begin
    shift_on = key_map[KIDX_W'(KEY_LSHIFT)] | key_map[KIDX_W'(KEY_RSHIFT)];
    if (is_letter(ev_key) && key_map[KIDX_W'(KEY_CAPS)]) begin
      shift_on = !shift_on;
    end
    if (ev_key >= ASCII_LIMIT) begin
      ev_char = 8'h00;
    end else if (shift_on) begin
      ev_char = shift_char(ev_key[5:0]);
    end else begin
      ev_char = plain_char(ev_key[5:0]);
    end
  end

  // Apply the event or the clear command to the key map
  always_comb begin
    ev_ok             = ev_valid && (ev_key != 8'h00) && ({1'b0, ev_key} < KEY_LIMIT);
    ev_idx            = ev_key[KIDX_W-1:0];
    key_map_next      = key_map;
    last_pressed_next = last_pressed;
    key_push          = '0;
    if (step.fire && step.cmd == CMD_CLEAR) begin
      key_map_next      = '0;
      last_pressed_next = 7'h00;
    end else if (ev_ok) begin
      if (ev_key == KEY_CAPS && ev_down) begin
        key_map_next[ev_idx] = !key_map[ev_idx];
        last_pressed_next    = ev_key[6:0];
      end else begin
        key_map_next[ev_idx] = ev_down;
        if (ev_down) begin
          last_pressed_next = ev_key[6:0];
          key_push.valid    = (ev_char != 8'h00);
          key_push.data     = ev_char;
        end
      end
    end
  end

  // Answer a key query from the map before this step
  assign key_is_down = step.fire && (step.cmd == CMD_QUERY) &&
                       key_map[KIDX_W'(step.key_index)];
  assign last_key    = last_pressed_next;

  // Hold the key state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_map      <= '0;
      last_pressed <= 7'h00;
      ext_pending  <= 1'b0;
      skip_left    <= 3'd0;
    end else begin
      key_map      <= key_map_next;
      last_pressed <= last_pressed_next;
      ext_pending  <= ext_pending_next;
      skip_left    <= skip_left_next;
    end
  end

endmodule

`default_nettype wire

### rtl/scd_ring.sv
// ---------------------------------------------------------------------------
// scd_ring
// Character ring with head and tail pointers and a prefetched tail entry.
// ---------------------------------------------------------------------------
`default_nettype none

`include "scan_code_keyboard_decoder_assert.svh"

module scd_ring import scd_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire step_t      step,
  input  wire push_t      key_push,
  output logic [7:0]      char_out,
  output logic            char_valid,
  output logic [5:0]      queue_count
);

  localparam int               PTR_W   = $clog2(RING_DEPTH);
  localparam int               CNT_W   = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);

  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       tail_data;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] tail_next;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  push_t            push_req;
  logic             wr_en;
  logic [CNT_W-1:0] count_next;

  // Pick the character to enqueue and step the pointers
  always_comb begin
    push_req   = (step.fire && step.cmd == CMD_PUSH) ? {1'b1, step.push_char} : key_push;
    head_inc   = (head == PTR_MAX) ? '0 : head + PTR_W'(1);
    tail_inc   = (tail == PTR_MAX) ? '0 : tail + PTR_W'(1);
    head_next  = head;
    tail_next  = tail;
    wr_en      = 1'b0;
    char_out   = 8'h00;
    char_valid = 1'b0;
    // drop the character when the ring is full
    if (push_req.valid && head_inc != tail) begin
      wr_en     = 1'b1;
      head_next = head_inc;
    end
    if (step.fire && step.cmd == CMD_POP && head != tail) begin
      char_out   = tail_data;
      char_valid = 1'b1;
      tail_next  = tail_inc;
    end
    if (step.fire && step.cmd == CMD_FLUSH) begin
      tail_next = head;
    end
  end

  // Count the characters left after this step
  always_comb begin
    if (head_next >= tail_next) begin
      count_next = CNT_W'(head_next) - CNT_W'(tail_next);
    end else begin
      count_next = CNT_W'(head_next) + DEPTH_C - CNT_W'(tail_next);
    end
  end

  assign queue_count = 6'(count_next);

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Write the ring at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[head] <= push_req.data;
    end
  end

  // Prefetch the entry at the new tail, forwarding a write to that entry
  always_ff @(posedge clk) begin
    if (wr_en && head == tail_next) begin
      tail_data <= push_req.data;
    end else begin
      tail_data <= ring_mem[tail_next];
    end
  end

  `SCD_ASSERT_NOW(a_ptr_range, 1'b1, ({1'b0, head} < DEPTH_C) && ({1'b0, tail} < DEPTH_C), "ring pointer out of range")
  `SCD_ASSERT_NOW(a_pop_empty, step.fire && step.cmd == CMD_POP && head == tail, !char_valid, "pop of empty ring gave a character")
  `SCD_ASSERT_NEXT(a_flush_empty, step.fire && step.cmd == CMD_FLUSH, head == tail, "flush left characters in the ring")
  `SCD_ASSERT_NEXT(a_fwd_write, wr_en && head == tail_next, tail_data == $past(push_req.data), "tail entry missed a write forward")

endmodule

`default_nettype wire

### bench/tb_scan_code_keyboard_decoder.sv
// ---------------------------------------------------------------------------
// tb_scan_code_keyboard_decoder
// Self-checking bench for the set-1 scan code decoder. Commands go in on the
// slave stream and one result per command comes back on the master stream.
// A scoreboard class predicts every result from its own copy of the key map,
// prefix state and character ring. A directed opening covers the corner
// cases. Random typing, extended and Pause sequences, ring traffic and noise
// follow, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_scan_code_keyboard_decoder;
  import scd_pkg::*;

  localparam int KEY_TOTAL  = KEY_COUNT_DEF;
  localparam int RING_SLOTS = RING_DEPTH_DEF;
  localparam int NO_KEY     = 256;
  localparam int ITEM_GOAL  = 1730;

  // Characters of keys 0x00..0x39, unshifted and shifted
  localparam logic [0:57][7:0] PLAIN_CHARS = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
    8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };
  localparam logic [0:57][7:0] SHIFT_CHARS = {
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
    8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
    8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Codes that have an entry in the extended key map
  localparam logic [0:14][6:0] EXT_CODES = {
    7'h48, 7'h50, 7'h4B, 7'h4D, 7'h52, 7'h53, 7'h47, 7'h4F,
    7'h49, 7'h51, 7'h38, 7'h1D, 7'h35, 7'h1C, 7'h37
  };

  typedef struct packed {
    cmd_t       op;
    logic [7:0] raw;
    logic [6:0] key;
    logic       pressed;
    logic [7:0] push;
  } kbd_cmd_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       key_is_down;
    logic [6:0] last_key;
    logic [5:0] queue_count;
  } kbd_result_t;

  // Keyboard state tracker and result checker
  class decoder_scoreboard;
    logic [KEY_TOTAL-1:0] key_down;
    logic [6:0]           last_key;
    logic [7:0]           ring [RING_SLOTS];
    logic [5:0]           head;
    logic [5:0]           tail;
    logic                 ext_pending;
    logic [2:0]           skip_left;
    kbd_result_t          expected_results[$];
    int                   mismatch_count;

    function new();
      key_down       = '0;
      last_key       = '0;
      head           = '0;
      tail           = '0;
      ext_pending    = 1'b0;
      skip_left      = '0;
      mismatch_count = 0;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    // Drop the character when the ring already holds 63
    function void ring_store(logic [7:0] ch);
      if (head + 6'd1 == tail) return;
      ring[head] = ch;
      head = head + 6'd1;
    endfunction

    function logic [7:0] ascii_of(int unsigned k);
      logic shifted;
      if (k >= ASCII_LIMIT) return 8'h00;
      shifted = key_down[KEY_LSHIFT] | key_down[KEY_RSHIFT];
      // Caps Lock flips shift on letters only
      if (((k >= 'h10 && k <= 'h19) || (k >= 'h1E && k <= 'h26) ||
           (k >= 'h2C && k <= 'h32)) && key_down[KEY_CAPS])
        shifted = !shifted;
      return shifted ? SHIFT_CHARS[k] : PLAIN_CHARS[k];
    endfunction

    function int unsigned ext_key_of(logic [6:0] code);
      case (code)
        7'h48: return 'h5A;
        7'h50: return 'h6A;
        7'h4B: return 'h6B;
        7'h4D: return 'h6C;
        7'h52: return 'h5E;
        7'h53: return 'h5F;
        7'h47: return 'h61;
        7'h4F: return 'h62;
        7'h49: return 'h63;
        7'h51: return 'h64;
        7'h38: return 'hB8;
        7'h1D: return 'h9D;
        7'h35: return 'hB5;
        7'h1C: return 'h9C;
        7'h37: return 'hB7;
        default: return NO_KEY;
      endcase
    endfunction

    function void key_event(int unsigned k, logic down);
      logic [7:0] ch;
      if (k == 0 || k >= KEY_TOTAL) return;
      // Caps Lock press toggles instead of setting
      if (k == KEY_CAPS && down) begin
        key_down[k] = ~key_down[k];
        last_key = k[6:0];
        return;
      end
      key_down[k] = down;
      if (!down) return;
      last_key = k[6:0];
      ch = ascii_of(k);
      if (ch != 8'h00) ring_store(ch);
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned k;
      // Swallow everything inside the Pause sequence
      if (skip_left != 0) begin
        skip_left = skip_left - 3'd1;
        return;
      end
      if (b == BYTE_PAUSE) begin
        key_event(KEY_PAUSE, 1'b1);
        skip_left = PAUSE_SKIP;
        return;
      end
      if (b == BYTE_EXT) begin
        ext_pending = 1'b1;
        return;
      end
      if (ext_pending) begin
        ext_pending = 1'b0;
        if (b[6:0] == FAKE_SHIFT) return;
        k = ext_key_of(b[6:0]);
      end else begin
        k = b[6:0];
      end
      if (k != NO_KEY) key_event(k, !b[7]);
    endfunction

    // Advance the state by one accepted command and queue its result
    function void note_command(kbd_cmd_t c);
      kbd_result_t r;
      r = '0;
      case (c.op)
        CMD_RAW:   take_byte(c.raw);
        CMD_KEY:   key_event(c.key, c.pressed);
        CMD_POP: begin
          if (head != tail) begin
            r.char_out   = ring[tail];
            r.char_valid = 1'b1;
            tail = tail + 6'd1;
          end
        end
        CMD_PUSH:  ring_store(c.push);
        CMD_FLUSH: tail = head;
        CMD_CLEAR: begin
          key_down = '0;
          last_key = '0;
        end
        CMD_QUERY: r.key_is_down = key_down[c.key];
        default: ;
      endcase
      r.last_key    = last_key;
      r.queue_count = head - tail;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [23:0] word);
      kbd_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual 0x%06h",
                 $time, word);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("char_out", want.char_out, word[7:0]);
      compare_field("char_valid", want.char_valid, word[8]);
      compare_field("key_is_down", want.key_is_down, word[9]);
      compare_field("last_key", want.last_key, word[16:10]);
      compare_field("queue_count", want.queue_count, word[22:17]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  decoder_scoreboard board;
  int   items_sent  = 0;
  bit   sender_fast = 1'b0;
  bit   reader_fast = 1'b0;
  bit   long_hold   = 1'b0;

  scan_code_keyboard_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Offer one command after a random gap and hold it until the transfer
  task automatic issue(input cmd_t op, input logic [7:0] raw, input logic [6:0] key,
                       input logic pressed, input logic [7:0] push);
    kbd_cmd_t c;
    int       gap;
    c.op = op;
    c.raw = raw;
    c.key = key;
    c.pressed = pressed;
    c.push = push;
    if ($urandom_range(0, 49) == 0) sender_fast = !sender_fast;
    gap = sender_fast ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, push, pressed, key, raw, op};
    do @(posedge clk); while (!s_tready);
    board.note_command(c);
    items_sent++;
  endtask

  // Keyboard byte with random filler in the unused fields
  task automatic feed_byte(input logic [7:0] b);
    issue(CMD_RAW, b, $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  // Withdraw the offer so the last command is not taken again, then wait
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) reader_fast = !reader_fast;
      gap = reader_fast ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_result(m_tdata);
    end
  end

  // Command side
  initial begin
    int n;
    int k;
    int sh;
    int next_drain;
    bit hold_done;
    board = new();
    next_drain = 400;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Ring basics, empty pop, key zero, top key
    issue(CMD_PUSH, 8'h00, 7'h00, 1'b0, 8'hFF);
    issue(CMD_PUSH, 8'hFF, 7'h7F, 1'b1, 8'h00);
    repeat (3) issue(CMD_POP, 8'h00, 7'h00, 1'b0, 8'h00);
    issue(CMD_KEY, 8'h00, 7'h00, 1'b1, 8'h00);
    issue(CMD_KEY, 8'hFF, 7'h7F, 1'b1, 8'hFF);
    issue(CMD_QUERY, 8'h00, 7'h7F, 1'b0, 8'h00);
    issue(CMD_QUERY, 8'h00, 7'h00, 1'b0, 8'h00);
    // Shifted letter and symbol, then Caps Lock on a letter and its release
    feed_byte(8'h2A);
    feed_byte(8'h1E);
    feed_byte(8'h02);
    feed_byte(8'hAA);
    feed_byte(8'h3A);
    feed_byte(8'h10);
    feed_byte(8'hBA);
    // Extended prefix before the fake shift, then before an unmapped code
    feed_byte(BYTE_EXT);
    feed_byte(8'h2A);
    feed_byte(BYTE_EXT);
    feed_byte(8'h01);
    // Pause with a pending extended mark and prefixes inside the skip
    feed_byte(BYTE_EXT);
    feed_byte(BYTE_PAUSE);
    feed_byte(BYTE_EXT);
    feed_byte(BYTE_PAUSE);
    feed_byte(8'hFF);
    feed_byte(8'h00);
    feed_byte(8'h80);
    feed_byte(8'h48);
    issue(CMD_FLUSH, 8'h00, 7'h00, 1'b0, 8'h00);
    issue(CMD_CLEAR, 8'h00, 7'h00, 1'b0, 8'h00);
    issue(CMD_NOP, 8'hFF, 7'h7F, 1'b1, 8'hFF);
    wait_results_drained();

    while (items_sent < ITEM_GOAL) begin
      // Let every result come home now and then
      if (items_sent >= next_drain) begin
        wait_results_drained();
        next_drain += 400;
      end
      // Stall the result side once while commands keep coming back to back
      if (!hold_done && items_sent >= 900) begin
        hold_done = 1'b1;
        long_hold = 1'b1;
        sender_fast = 1'b1;
        repeat (24)
          issue(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 127),
                $urandom_range(0, 1), $urandom_range(0, 255));
      end
      case ($urandom_range(0, 10))
        0, 1, 2: begin
          // Typing burst, sometimes under shift
          n = $urandom_range(1, 6);
          sh = 0;
          if ($urandom_range(0, 3) == 0) sh = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
          if (sh != 0) feed_byte(sh);
          repeat (n) begin
            k = $urandom_range(1, 'h39);
            feed_byte(k);
            if ($urandom_range(0, 3) != 0) feed_byte(k | 'h80);
          end
          if (sh != 0) feed_byte(sh | 'h80);
        end
        3: begin
          feed_byte(KEY_CAPS);
          if ($urandom_range(0, 1)) feed_byte(KEY_CAPS | 'h80);
        end
        4: begin
          // Extended prefix followed by mapped, fake shift or any code
          feed_byte(BYTE_EXT);
          case ($urandom_range(0, 3))
            0:       k = FAKE_SHIFT;
            1:       k = $urandom_range(0, 127);
            default: k = EXT_CODES[$urandom_range(0, 14)];
          endcase
          feed_byte(k | ($urandom_range(0, 1) << 7));
        end
        5: begin
          // Pause sequence, skipped bytes may hold prefixes
          if ($urandom_range(0, 2) == 0) feed_byte(BYTE_EXT);
          feed_byte(BYTE_PAUSE);
          repeat (5) begin
            case ($urandom_range(0, 3))
              0:       feed_byte(BYTE_EXT);
              1:       feed_byte(BYTE_PAUSE);
              default: feed_byte($urandom_range(0, 255));
            endcase
          end
          feed_byte($urandom_range(0, 255));
        end
        6, 7: begin
          n = $urandom_range(1, 12);
          repeat (n)
            issue(CMD_POP, $urandom_range(0, 255), $urandom_range(0, 127),
                  $urandom_range(0, 1), $urandom_range(0, 255));
        end
        8: begin
          // Pushes, now and then enough to overflow the ring
          n = ($urandom_range(0, 7) == 0) ? 70 : $urandom_range(1, 8);
          repeat (n)
            issue(CMD_PUSH, $urandom_range(0, 255), $urandom_range(0, 127),
                  $urandom_range(0, 1), $urandom_range(0, 255));
        end
        9: begin
          case ($urandom_range(0, 5))
            0, 1:    k = CMD_KEY;
            2:       k = CMD_QUERY;
            3:       k = CMD_FLUSH;
            4:       k = CMD_CLEAR;
            default: k = CMD_NOP;
          endcase
          issue(cmd_t'(k), $urandom_range(0, 255), $urandom_range(0, 127),
                $urandom_range(0, 1), $urandom_range(0, 255));
        end
        default: begin
          issue(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 255),
                $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 255));
        end
      endcase
    end

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (board.mismatch_count == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/scd_pkg.sv
rtl/scd_keys.sv
rtl/scd_ring.sv
rtl/scan_code_keyboard_decoder.sv
bench/tb_scan_code_keyboard_decoder.sv
